// File: sv/brpc_pkg.sv
package brpc_pkg;

    // Motion states as they appear on the result channel.
    typedef enum logic [2:0] {
        MOTION_STOP      = 3'd0,
        MOTION_PREP_UP   = 3'd1,
        MOTION_UP        = 3'd2,
        MOTION_PREP_DOWN = 3'd3,
        MOTION_DOWN      = 3'd4
    } t_motion;

    // Operation codes of an input transaction.
    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_DOWN = 3'd1;
    localparam logic [2:0] OP_UP   = 3'd2;
    localparam logic [2:0] OP_SET  = 3'd3;
    localparam logic [2:0] OP_STOP = 3'd4;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [1:0] REG_INTERLOCK = 2'd0;
    localparam logic [1:0] REG_UP_STEP   = 2'd1;
    localparam logic [1:0] REG_DOWN_STEP = 2'd2;

    // Interlock wiring modes.
    localparam logic [2:0] MODE_PWR_UP   = 3'd0;
    localparam logic [2:0] MODE_PWR_DOWN = 3'd1;
    localparam logic [2:0] MODE_UP_DOWN  = 3'd2;
    localparam logic [2:0] MODE_DOWN_UP  = 3'd3;
    localparam logic [2:0] MODE_UP_PWR   = 3'd4;
    localparam logic [2:0] MODE_DOWN_PWR = 3'd5;

    // Position landmarks.
    localparam logic [30:0] POS_MAX       = 31'd2147483647;
    localparam logic [30:0] POS_PERM_DOWN = 31'd1;
    localparam logic [30:0] POS_SAFE_DOWN = 31'd214748364;
    localparam logic [30:0] POS_FULL_DOWN = 31'd536870911;
    localparam logic [30:0] POS_FULL_UP   = 31'd1610612735;
    localparam logic [30:0] POS_SAFE_UP   = 31'd1932735282;

    localparam logic [9:0]  DWELL_MAX      = 10'd1023;
    localparam logic [19:0] STEP_RESET     = 20'd35791;

endpackage

// File: sv/blind_relay_position_controller_unit.sv
// Blind relay position controller.
// Input channel (i_in_valid / o_in_ready) carries one transaction per command
// or millisecond tick: op, forced, target and elapsed_ms. Every input
// transaction yields exactly one result transaction on the output channel
// (o_out_valid / i_out_ready): both relay levels, the motion state and the
// estimated position after that item.
// An item is captured in an input register, updated against the controller
// state combinationally with one 10x20 multiplier, and placed in the result
// register, which drives o_out_valid; a stalled result register holds the item
// in the input register until the receiver takes the result. One item
// per cycle is accepted while the receiver keeps taking results.
// When the receiver stalls, the result register holds its transaction and the
// input register holds the next one; o_in_ready drops only when both are full.
// Synchronous active-low reset empties both registers, stops the motor with
// both relays inactive and sets goal and estimate to full up.
// Configuration is an APB-style port: interlock_mode at 0x0, up_step at 0x4,
// down_step at 0x8; pready is always high and writes land in the access cycle.
module blind_relay_position_controller_unit
    import brpc_pkg::*;
#(
    parameter int STOP_DWELL_MS    = 500,
    parameter int PREPARE_DWELL_MS = 200
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_op,
    input  logic        i_forced,
    input  logic [14:0] i_target,
    input  logic [9:0]  i_elapsed_ms,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_relay_a,
    output logic        o_relay_b,
    output logic [2:0]  o_motion_state,
    output logic [30:0] o_position
);

    localparam logic [9:0] STOP_DWELL = 10'(STOP_DWELL_MS);
    localparam logic [9:0] PREP_DWELL = 10'(PREPARE_DWELL_MS);

    // Configuration registers
    logic [2:0]  r_mode;
    logic [19:0] r_up_step;
    logic [19:0] r_down_step;

    // Controller state
    t_motion     r_motion, n_motion;
    logic [30:0] r_goal, n_goal;
    logic [30:0] r_estimate, n_estimate;
    logic [9:0]  r_dwell, n_dwell;
    logic [1:0]  r_relays, n_relays;

    // Input register
    logic        r_s1_vld;
    logic [2:0]  r_s1_op;
    logic        r_s1_forced;
    logic [14:0] r_s1_target;
    logic [9:0]  r_s1_elapsed;

    // Result register
    logic        r_out_vld;
    logic        r_out_relay_a;
    logic        r_out_relay_b;
    t_motion     r_out_motion;
    logic [30:0] r_out_position;

    logic advance;
    logic cfg_write;

    assign advance    = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || advance;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    // Register write and readback.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_PWR_UP;
            r_up_step   <= STEP_RESET;
            r_down_step <= STEP_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_INTERLOCK: r_mode      <= pwdata[2:0];
                REG_UP_STEP:   r_up_step   <= pwdata[19:0];
                REG_DOWN_STEP: r_down_step <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_INTERLOCK: prdata = {29'd0, r_mode};
            REG_UP_STEP:   prdata = {12'd0, r_up_step};
            REG_DOWN_STEP: prdata = {12'd0, r_down_step};
            default:       prdata = 32'd0;
        endcase
    end

    // Position integration: one multiplier shared by both directions.
    logic [19:0]        step_sel;
    logic [29:0]        travel;
    logic [31:0]        est_add;
    logic [31:0]        est_sub;
    logic [30:0]        est_moved;
    logic signed [31:0] goal_diff;
    logic signed [31:0] up_thr;
    logic signed [31:0] down_thr;
    logic               want_up;
    logic               want_down;
    logic [10:0]        dwell_sum;
    logic [9:0]         dwell_acc;
    logic               is_tick;

    assign is_tick  = (r_s1_op == OP_TICK);
    assign step_sel = (r_motion == MOTION_UP) ? r_up_step : r_down_step;
    assign travel   = r_s1_elapsed * step_sel;
    assign est_add  = {1'b0, r_estimate} + {2'b00, travel};
    assign est_sub  = {1'b0, r_estimate} - {2'b00, travel};

    always_comb begin
        case (r_motion)
            MOTION_UP:   est_moved = est_add[31] ? POS_MAX : est_add[30:0];
            MOTION_DOWN: est_moved = est_sub[31] ? 31'd0 : est_sub[30:0];
            default:     est_moved = r_estimate;
        endcase
    end

    // Direction decisions use the estimate after this tick's travel.
    assign goal_diff = $signed({1'b0, r_goal}) - $signed({1'b0, est_moved});
    assign up_thr    = $signed({2'b00, r_up_step, 10'd0});
    assign down_thr  = -$signed({2'b00, r_down_step, 10'd0});
    assign want_up   = goal_diff > up_thr;
    assign want_down = goal_diff < down_thr;

    assign dwell_sum = {1'b0, r_dwell} + {1'b0, r_s1_elapsed};
    assign dwell_acc = dwell_sum[10] ? DWELL_MAX : dwell_sum[9:0];

    // Next motion state, evaluated on ticks only.
    always_comb begin
        n_motion = r_motion;
        if (is_tick) begin
            if (r_goal == 31'd0) begin
                n_motion = MOTION_STOP;
            end else if (r_motion == MOTION_STOP && dwell_acc >= STOP_DWELL) begin
                if (want_up) begin
                    n_motion = MOTION_PREP_UP;
                end else if (want_down) begin
                    n_motion = MOTION_PREP_DOWN;
                end else begin
                    n_motion = MOTION_STOP;
                end
            end else if (r_motion == MOTION_PREP_DOWN && dwell_acc >= PREP_DWELL) begin
                n_motion = want_down ? MOTION_DOWN : MOTION_STOP;
            end else if (r_motion == MOTION_PREP_UP && dwell_acc >= PREP_DWELL) begin
                n_motion = want_up ? MOTION_UP : MOTION_STOP;
            end else if (r_motion == MOTION_UP && est_moved >= r_goal) begin
                n_motion = MOTION_STOP;
            end else if (r_motion == MOTION_DOWN && est_moved <= r_goal) begin
                n_motion = MOTION_STOP;
            end
        end
    end

    // A state is entered when a tick rule fires; a stop that repeats counts too.
    logic entered;

    always_comb begin
        entered = 1'b0;
        if (is_tick) begin
            if (r_goal == 31'd0) begin
                entered = 1'b1;
            end else if (r_motion == MOTION_STOP) begin
                entered = (dwell_acc >= STOP_DWELL);
            end else if (r_motion == MOTION_PREP_DOWN || r_motion == MOTION_PREP_UP) begin
                entered = (dwell_acc >= PREP_DWELL);
            end else if (r_motion == MOTION_UP) begin
                entered = (est_moved >= r_goal);
            end else if (r_motion == MOTION_DOWN) begin
                entered = (est_moved <= r_goal);
            end
        end
    end

    // Relay drive, dwell timer and estimate that follow the state entered.
    always_comb begin
        n_relays   = r_relays;
        n_dwell    = r_dwell;
        n_estimate = r_estimate;
        if (is_tick) begin
            n_estimate = est_moved;
            n_dwell    = entered ? 10'd0 : dwell_acc;
            if (entered) begin
                unique case (n_motion)
                    MOTION_STOP: begin
                        n_relays = 2'b00;
                        if (est_moved > POS_FULL_UP) begin
                            n_estimate = POS_FULL_UP;
                        end else if (est_moved < POS_FULL_DOWN) begin
                            n_estimate = POS_FULL_DOWN;
                        end
                    end
                    MOTION_PREP_UP: begin
                        if (r_mode == MODE_PWR_UP) begin
                            n_relays[1] = 1'b1;
                        end else if (r_mode == MODE_UP_PWR) begin
                            n_relays[0] = 1'b1;
                        end
                    end
                    MOTION_UP: begin
                        if (r_mode <= MODE_UP_DOWN) begin
                            n_relays[0] = 1'b1;
                        end else if (r_mode <= MODE_DOWN_PWR) begin
                            n_relays[1] = 1'b1;
                        end
                    end
                    MOTION_PREP_DOWN: begin
                        if (r_mode == MODE_PWR_DOWN) begin
                            n_relays[1] = 1'b1;
                        end else if (r_mode == MODE_DOWN_PWR) begin
                            n_relays[0] = 1'b1;
                        end
                    end
                    MOTION_DOWN: begin
                        if (r_mode == MODE_PWR_UP || r_mode == MODE_PWR_DOWN
                            || r_mode == MODE_DOWN_UP) begin
                            n_relays[0] = 1'b1;
                        end else if (r_mode == MODE_UP_DOWN || r_mode == MODE_UP_PWR
                                     || r_mode == MODE_DOWN_PWR) begin
                            n_relays[1] = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Goal updates from commands.
    always_comb begin
        n_goal = r_goal;
        case (r_s1_op)
            OP_DOWN: begin
                if (r_s1_forced) begin
                    n_goal = POS_PERM_DOWN;
                end else begin
                    n_goal = (r_goal == 31'd0) ? POS_SAFE_DOWN : 31'd0;
                end
            end
            OP_UP: begin
                if (r_s1_forced) begin
                    n_goal = POS_MAX;
                end else begin
                    n_goal = (r_goal == 31'd0) ? POS_SAFE_UP : 31'd0;
                end
            end
            OP_SET:  n_goal = {r_s1_target, 16'd0};
            OP_STOP: n_goal = 31'd0;
            default: ;
        endcase
    end

    // Controller state advances with each transaction leaving the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion   <= MOTION_STOP;
            r_goal     <= POS_FULL_UP;
            r_estimate <= POS_FULL_UP;
            r_dwell    <= 10'd0;
            r_relays   <= 2'b00;
        end else if (advance) begin
            r_motion   <= n_motion;
            r_goal     <= n_goal;
            r_estimate <= n_estimate;
            r_dwell    <= n_dwell;
            r_relays   <= n_relays;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_op      <= i_op;
            r_s1_forced  <= i_forced;
            r_s1_target  <= i_target;
            r_s1_elapsed <= i_elapsed_ms;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_relay_a  <= n_relays[0];
            r_out_relay_b  <= n_relays[1];
            r_out_motion   <= n_motion;
            r_out_position <= n_estimate;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_relay_a      = r_out_relay_a;
    assign o_relay_b      = r_out_relay_b;
    assign o_motion_state = r_out_motion;
    assign o_position     = r_out_position;

endmodule

// File: sv/brpc_checker.sv
module brpc_checker
    import brpc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_relay_a,
    input logic        o_relay_b,
    input logic [2:0]  o_motion_state,
    input logic [30:0] o_position
);

    // Reset empties the result register by the next cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result transaction keeps its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_position)
            && $stable(o_motion_state) && $stable(o_relay_a) && $stable(o_relay_b))
        else $error("stalled result changed");

    // A stopped motor never drives a relay.
    a_stop_relays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_motion_state == MOTION_STOP |-> !o_relay_a && !o_relay_b)
        else $error("relay active while stopped");

    // While stopped, the estimate lies within the clamped travel range.
    a_stop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_motion_state == MOTION_STOP
            |-> o_position >= POS_FULL_DOWN && o_position <= POS_FULL_UP)
        else $error("stopped position out of range");

endmodule

bind blind_relay_position_controller_unit brpc_checker u_brpc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_relay_a      (o_relay_a),
    .o_relay_b      (o_relay_b),
    .o_motion_state (o_motion_state),
    .o_position     (o_position)
);
